/* src/sal_pkg.sv */
// ----------------------------------------------------------------------------
// sal_pkg
// Shared request/status codes and the command and status bundles that pass
// between the list controller and its datapath.
// ----------------------------------------------------------------------------
package sal_pkg;

    // Item field widths
    localparam int REQ_W   = 3;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Request types
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // RAM write selects
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_APPEND = 2'd1;
    localparam logic [1:0] WR_POS    = 2'd2;
    localparam logic [1:0] WR_SHIFT  = 2'd3;

    // RAM read selects
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_POS  = 2'd1;
    localparam logic [1:0] RD_DN   = 2'd2;
    localparam logic [1:0] RD_UP   = 2'd3;

    // Shift index updates
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_COUNT = 3'd1;
    localparam logic [2:0] IDX_POS   = 3'd2;
    localparam logic [2:0] IDX_DEC   = 3'd3;
    localparam logic [2:0] IDX_INC   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic              latch;
        logic [1:0]        wr_sel;
        logic [1:0]        rd_sel;
        logic [2:0]        idx_sel;
        logic              count_inc;
        logic              count_dec;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
        logic              res_take_rdata;
        logic              out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             in_range;
        logic             full;
        logic             idx_at_pos;
        logic             idx_last;
        logic             out_free;
    } sts_t;

endpackage

/* src/shifting_array_list.sv */
// ----------------------------------------------------------------------------
// shifting_array_list
// Ordered list of up to CAPACITY signed 32-bit entries with append, insert,
// update, remove and read, one result item per request item.
// ----------------------------------------------------------------------------
// The entries live in a single-port-write, single-port-read RAM, so one
// item is worked at a time. Each item is accepted, decoded and finished;
// a read also waits for the registered RAM data before it finishes. Insert
// at index p moves the entries from the tail down to p up by one, and remove
// moves the entries above p down by one: each moved entry costs one RAM read followed by one
// RAM write. The result sits in an output register, so the next item is
// taken while a finished result waits on out_stall. The entries need no
// clearing after reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module shifting_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sal_pkg::REQ_W-1:0]   req_type,
    input  logic [sal_pkg::POS_W-1:0]   position,
    input  logic [sal_pkg::DATA_W-1:0]  item_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sal_pkg::DATA_W-1:0]  read_data,
    output logic [sal_pkg::COUNT_W-1:0] entry_count,
    output logic [sal_pkg::STAT_W-1:0]  status
);
    import sal_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    sal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage and result path
    sal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .position    (position),
        .item_value  (item_value),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .read_data   (read_data),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule

/* src/sal_ram.sv */
// ----------------------------------------------------------------------------
// sal_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sal_dp.sv */
// ----------------------------------------------------------------------------
// sal_dp
// List datapath: request capture, entry RAM, count and shift index,
// result and output registers.
// ----------------------------------------------------------------------------
module sal_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sal_pkg::REQ_W-1:0]     req_type,
    input  logic [sal_pkg::POS_W-1:0]     position,
    input  logic [sal_pkg::DATA_W-1:0]    item_value,
    input  sal_pkg::cmd_t                 cmd,
    output sal_pkg::sts_t                 sts,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [sal_pkg::DATA_W-1:0]    read_data,
    output logic [sal_pkg::COUNT_W-1:0]   entry_count,
    output logic [sal_pkg::STAT_W-1:0]    status
);
    import sal_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;
    localparam int WW  = (CW > POS_W) ? CW : POS_W;

    logic [REQ_W-1:0]   req_type_reg, req_type_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [DATA_W-1:0]  res_data_reg, res_data_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DATA_W-1:0]  rd_data;

    logic [WW-1:0]      pos_w;
    logic [WW-1:0]      count_w;
    logic [WW-1:0]      idx_w;
    logic [CW-1:0]      idx_dn;
    logic [CW-1:0]      idx_up;

    // Entry storage
    sal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Index compares in a common width
    assign pos_w   = WW'(pos_reg);
    assign count_w = WW'(count_reg);
    assign idx_w   = WW'(idx_reg);
    assign idx_dn  = idx_reg - CW'(1);
    assign idx_up  = idx_reg + CW'(1);

    assign sts.req_type   = req_type_reg;
    assign sts.in_range   = pos_w < count_w;
    assign sts.full       = count_reg == CW'(CAPACITY);
    assign sts.idx_at_pos = idx_w == pos_w;
    assign sts.idx_last   = (CW1'(idx_reg) + CW1'(1)) >= CW1'(count_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // RAM write port
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val_reg;
        case (cmd.wr_sel)
            WR_APPEND: wr_addr = AW'(count_reg);
            WR_POS:    wr_addr = AW'(pos_reg);
            WR_SHIFT:
            begin
                wr_addr = AW'(idx_reg);
                wr_data = rd_data;
            end
            default:   wr_en = 1'b0;
        endcase
    end

    // RAM read port
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (cmd.rd_sel)
            RD_POS:  rd_addr = AW'(pos_reg);
            RD_DN:   rd_addr = AW'(idx_dn);
            RD_UP:   rd_addr = AW'(idx_up);
            default: rd_en = 1'b0;
        endcase
    end

    // Request capture, count and shift index
    always_comb
    begin
        req_type_next = cmd.latch ? req_type   : req_type_reg;
        pos_next      = cmd.latch ? position   : pos_reg;
        val_next      = cmd.latch ? item_value : val_reg;

        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        case (cmd.idx_sel)
            IDX_COUNT: idx_next = count_reg;
            IDX_POS:   idx_next = CW'(pos_reg);
            IDX_DEC:   idx_next = idx_dn;
            IDX_INC:   idx_next = idx_up;
            default:   idx_next = idx_reg;
        endcase
    end

    // Result and output registers
    always_comb
    begin
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        if (cmd.res_load)
        begin
            res_status_next = cmd.res_status;
            res_data_next   = '0;
        end
        else if (cmd.res_take_rdata)
        begin
            res_data_next = rd_data;
        end

        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res_data_reg;
            out_count_next  = COUNT_W'(count_reg);
            out_status_next = res_status_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_data_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

/* src/sal_ctrl.sv */
// ----------------------------------------------------------------------------
// sal_ctrl
// List controller: decodes each item and steps the datapath through
// the entry shift, one RAM read and one RAM write per moved entry.
// ----------------------------------------------------------------------------
module sal_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  sal_pkg::sts_t sts,
    output sal_pkg::cmd_t cmd
);
    import sal_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_INS_RD  = 3'd2;
    localparam logic [2:0] S_INS_WR  = 3'd3;
    localparam logic [2:0] S_REM_RD  = 3'd4;
    localparam logic [2:0] S_REM_WR  = 3'd5;
    localparam logic [2:0] S_RD_WAIT = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_stall = state_reg != S_IDLE;

    // Next state and commands
    always_comb
    begin
        state_next         = state_reg;
        cmd                = '0;
        cmd.wr_sel         = WR_NONE;
        cmd.rd_sel         = RD_NONE;
        cmd.idx_sel        = IDX_HOLD;
        cmd.res_status     = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_FINISH;
                case (sts.req_type)
                    REQ_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel    = WR_APPEND;
                            cmd.count_inc = 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.res_status = ST_RANGE;
                        end
                        else if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_COUNT;
                            state_next  = S_INS_RD;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.res_status = ST_RANGE;
                        end
                        else
                        begin
                            cmd.wr_sel = WR_POS;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.res_status = ST_RANGE;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_POS;
                            state_next  = S_REM_RD;
                        end
                    end
                    REQ_READ:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.res_status = ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_POS;
                            state_next = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        // unknown request: no change, plain ok
                    end
                endcase
            end

            // Insert: move entries up from the tail, then drop the value in
            S_INS_RD:
            begin
                if (sts.idx_at_pos)
                begin
                    cmd.wr_sel    = WR_POS;
                    cmd.count_inc = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_DN;
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_sel = IDX_DEC;
                state_next  = S_INS_RD;
            end

            // Remove: move entries down from the hole to the tail
            S_REM_RD:
            begin
                if (sts.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_UP;
                    state_next = S_REM_WR;
                end
            end

            S_REM_WR:
            begin
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_sel = IDX_INC;
                state_next  = S_REM_RD;
            end

            S_RD_WAIT:
            begin
                cmd.res_take_rdata = 1'b1;
                state_next         = S_FINISH;
            end

            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* tb/shifting_array_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shifting_array_list_checker
// Watches the request and result channels of the list block. Every accepted
// request is applied to a private copy of the list, and the answer it should
// produce is queued. Every accepted result is compared field by field with
// the oldest queued answer. Failures and run statistics go to the top.
// ----------------------------------------------------------------------------
module shifting_array_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [sal_pkg::REQ_W-1:0]   req_type,
    input  logic [sal_pkg::POS_W-1:0]   position,
    input  logic [sal_pkg::DATA_W-1:0]  item_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [sal_pkg::DATA_W-1:0]  read_data,
    input  logic [sal_pkg::COUNT_W-1:0] entry_count,
    input  logic [sal_pkg::STAT_W-1:0]  status,
    output int                          fail_count,
    output int                          pending,
    output int                          checked,
    output int                          range_hits,
    output int                          full_hits,
    output int                          peak_len
);
    import sal_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  st;
    } list_answer_t;

    // Private copy of the list
    logic [DATA_W-1:0] list_cells [CAPACITY];
    int                list_len;

    // Answers still owed by the block, oldest first
    list_answer_t answers_owed [$];

    int n_fail;
    int n_checked;
    int n_range;
    int n_full;
    int n_peak;

    // Apply one request to the list copy and return the answer it gives
    function automatic list_answer_t apply_request(
        input logic [REQ_W-1:0]  kind,
        input logic [POS_W-1:0]  pos,
        input logic [DATA_W-1:0] val
    );
        list_answer_t ans;
        logic         hit;
        int           i;
        ans    = '0;
        ans.st = ST_OK;
        hit    = int'(pos) < list_len;
        case (kind)
            REQ_APPEND:
            begin
                if (list_len >= CAPACITY)
                    ans.st = ST_FULL;
                else
                begin
                    list_cells[list_len] = val;
                    list_len++;
                end
            end
            REQ_INSERT:
            begin
                // index check wins over the full check
                if (!hit)
                    ans.st = ST_RANGE;
                else if (list_len >= CAPACITY)
                    ans.st = ST_FULL;
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[pos] = val;
                    list_len++;
                end
            end
            REQ_UPDATE:
            begin
                if (!hit)
                    ans.st = ST_RANGE;
                else
                    list_cells[pos] = val;
            end
            REQ_REMOVE:
            begin
                if (!hit)
                    ans.st = ST_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            REQ_READ:
            begin
                if (!hit)
                    ans.st = ST_RANGE;
                else
                    ans.rdata = list_cells[pos];
            end
            default:
            begin
                // unknown request: no change, plain ok answer
            end
        endcase
        ans.count = COUNT_W'(list_len);
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            n_fail++;
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    // Score results, then predict newly accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        list_answer_t want;
        if (!rst_n)
        begin
            list_len = 0;
            answers_owed.delete();
            n_fail    = 0;
            n_checked = 0;
            n_range   = 0;
            n_full    = 0;
            n_peak    = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (answers_owed.size() == 0)
                begin
                    n_fail++;
                    $error("result with no request outstanding: read_data %0d count %0d status %0d",
                           $signed(read_data), entry_count, status);
                end
                else
                begin
                    want = answers_owed.pop_front();
                    n_checked++;
                    check_field("read_data", want.rdata, read_data);
                    check_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
                    check_field("status", DATA_W'(want.st), DATA_W'(status));
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                want = apply_request(req_type, position, item_value);
                if (want.st == ST_RANGE)
                    n_range++;
                if (want.st == ST_FULL)
                    n_full++;
                if (list_len > n_peak)
                    n_peak = list_len;
                answers_owed.push_back(want);
            end
        end
        fail_count <= n_fail;
        pending    <= answers_owed.size();
        checked    <= n_checked;
        range_hits <= n_range;
        full_hits  <= n_full;
        peak_len   <= n_peak;
    end

endmodule

/* tb/shifting_array_list_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shifting_array_list_tb
// Drives the list block with a short directed sequence (empty list errors,
// value extremes, insert/update/remove/read, unknown request codes) and then
// phases of random requests that grow the list to full, churn it and drain
// it to empty. Both sides idle in random bursts; once the receiver holds off
// long enough to back the block up. The checker scores every result.
// ----------------------------------------------------------------------------
module shifting_array_list_tb;
    import sal_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int PHASE_ITEMS  = 125;
    localparam int NUM_PHASES   = 10;
    localparam int HOLD_PHASE   = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 4000;

    // Request mix of a random phase
    typedef enum logic [1:0] {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_e;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   item_value;
    logic                out_valid;
    logic                out_stall;
    logic [DATA_W-1:0]   read_data;
    logic [COUNT_W-1:0]  entry_count;
    logic [STAT_W-1:0]   status;

    int fail_count;
    int pending;
    int checked;
    int range_hits;
    int full_hits;
    int peak_len;

    int idle_pct  = 0;
    bit hold_req  = 1'b0;
    int track_len = 0;
    int sent      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    shifting_array_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .position    (position),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .entry_count (entry_count),
        .status      (status)
    );

    shifting_array_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .position    (position),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .entry_count (entry_count),
        .status      (status),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .range_hits  (range_hits),
        .full_hits   (full_hits),
        .peak_len    (peak_len)
    );

    // Values lean on the signed extremes, zero and minus one
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal requests on the current list, a little noise
    task automatic pick_request(input mix_e mix, output logic [REQ_W-1:0] kind,
                                output logic [POS_W-1:0] pos,
                                output logic [DATA_W-1:0] val);
        int r;
        int t_app;
        int t_ins;
        int t_upd;
        int t_rem;
        r   = $urandom_range(0, 99);
        val = pick_value();
        case (mix)
            MIX_GROW:   begin t_app = 45; t_ins = 70; t_upd = 80; t_rem = 85; end
            MIX_SHRINK: begin t_app = 8;  t_ins = 15; t_upd = 25; t_rem = 85; end
            default:    begin t_app = 20; t_ins = 40; t_upd = 55; t_rem = 75; end
        endcase
        if (track_len > 0 && $urandom_range(0, 9) != 0)
            pos = POS_W'($urandom_range(0, track_len - 1));
        else
            pos = POS_W'($urandom);
        if ($urandom_range(0, 99) < 5)
            kind = REQ_W'($urandom_range(5, 7));
        else if (r < t_app)
            kind = REQ_APPEND;
        else if (r < t_ins)
            kind = REQ_INSERT;
        else if (r < t_upd)
            kind = REQ_UPDATE;
        else if (r < t_rem)
            kind = REQ_REMOVE;
        else
            kind = REQ_READ;
    endtask

    // Offer one item, hold it until taken, then follow the list length
    task automatic issue_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sent++;
        case (kind)
            REQ_APPEND:
                if (track_len < CAPACITY)
                    track_len++;
            REQ_INSERT:
                if (int'(pos) < track_len && track_len < CAPACITY)
                    track_len++;
            REQ_REMOVE:
                if (int'(pos) < track_len)
                    track_len--;
            default:
                ;
        endcase
    endtask

    // Result side: stall bursts, free runs, and one long hold-off
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req   = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    // Watchdog: the run must keep moving items
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending);
        $display("** shifting_array_list: FAILED **");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        mix_e              plan [NUM_PHASES];
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int                p;
        int                directed;
        plan = '{MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_GROW, MIX_GROW,
                 MIX_SHRINK, MIX_EVEN, MIX_SHRINK, MIX_GROW, MIX_EVEN};

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_APPEND;
        position   <= '0;
        item_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list errors, extremes, every operation
        idle_pct = 15;
        issue_request(REQ_READ,   6'd0,  32'h0000_0001);
        issue_request(REQ_INSERT, 6'd0,  32'h0000_0002);
        issue_request(REQ_UPDATE, 6'd0,  32'h0000_0003);
        issue_request(REQ_REMOVE, 6'd0,  32'h0000_0004);
        issue_request(REQ_APPEND, 6'd63, 32'h8000_0000);
        issue_request(REQ_APPEND, 6'd0,  32'h7fff_ffff);
        issue_request(REQ_APPEND, 6'd0,  32'h0000_0000);
        issue_request(REQ_INSERT, 6'd0,  32'h1234_5678);
        issue_request(REQ_INSERT, 6'd2,  32'hffff_ffff);
        issue_request(REQ_UPDATE, 6'd4,  32'ha5a5_a5a5);
        for (p = 0; p < 5; p++)
            issue_request(REQ_READ, POS_W'(p), 32'h0);
        // index equal to the count, and the top index
        issue_request(REQ_READ,   6'd5,  32'h0);
        issue_request(REQ_READ,   6'd63, 32'h0);
        issue_request(REQ_INSERT, 6'd5,  32'h5a5a_5a5a);
        // remove last, then first
        issue_request(REQ_REMOVE, 6'd4,  32'h0);
        issue_request(REQ_REMOVE, 6'd0,  32'h0);
        // unknown request codes
        issue_request(REQ_W'(5),  6'd63, 32'hffff_ffff);
        issue_request(REQ_W'(6),  6'd0,  32'h0);
        issue_request(REQ_W'(7),  6'd1,  32'h8000_0000);
        issue_request(REQ_READ,   6'd0,  32'h0);
        issue_request(REQ_READ,   6'd2,  32'h0);
        directed = sent;

        // Random phases; growth phases run the list into full
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                pick_request(plan[p], kind, pos, val);
                issue_request(kind, pos, val);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Coverage: %0d requests (%0d directed), %0d results scored, peak length %0d",
                 sent, directed, checked, peak_len);
        $display("          %0d index errors and %0d list-full answers expected, %0d failures",
                 range_hits, full_hits, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("** shifting_array_list: PASSED **");
        else
            $display("** shifting_array_list: FAILED **");
        $finish;
    end

endmodule
